[rtl/core/srrw_pkg.sv]
// Package for the selective-repeat receive window: widths, result kinds,
// controller states and the control/status structs shared by the modules.
// No dependencies.
`default_nettype none

package srrw_pkg;

  localparam int SEQ_W      = 32;
  localparam int LEN_W      = 12;
  localparam int HANDLE_W   = 32;
  localparam int ENTRY_W    = LEN_W + HANDLE_W;
  localparam int TDATA_W    = 80;
  localparam int TUSER_W    = 2;
  localparam int WINDOW_DEF = 32;

  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_READ,
    ST_DELIVER
  } state_t;

  // requests from the controller to the window tracker
  typedef struct packed {
    logic eval;
    logic deliver;
  } win_ctrl_t;

  // status from the window tracker
  typedef struct packed {
    logic stored;
    logic drain;
    logic done;
    logic next_held;
  } win_stat_t;

endpackage

`default_nettype wire

[rtl/core/srrw_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module srrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/srrw_window.sv]
// Window tracker: held flags, expected sequence, its slot and the final flag.
// Evaluates an arriving sequence number against the window. Uses srrw_pkg.
`default_nettype none

module srrw_window #(
  parameter int WINDOW = 32,
  parameter int SLOT_W = $clog2(WINDOW)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire srrw_pkg::win_ctrl_t      ctrl,
  input  wire logic [srrw_pkg::SEQ_W-1:0] seq,
  input  wire logic                     is_final,
  output srrw_pkg::win_stat_t           stat,
  output logic [srrw_pkg::SEQ_W-1:0]    ne_seq,
  output logic [SLOT_W-1:0]             ne_slot,
  output logic [SLOT_W-1:0]             next_slot,
  output logic [SLOT_W-1:0]             ins_slot
);

  import srrw_pkg::*;

  logic [WINDOW-1:0] held;
  logic [WINDOW-1:0] held_next;
  logic              final_seen;
  logic [SEQ_W:0]    diff;
  logic              in_win;
  logic [SLOT_W:0]   slot_sum;
  logic [WINDOW-1:0] mask_new;
  logic [WINDOW-1:0] prev;
  logic [WINDOW-1:0] starts;
  logic [WINDOW-1:0] ne_one;
  logic              final_new;

  // borrow in the top bit means seq lies below the expected sequence
  assign diff   = {1'b0, seq} - {1'b0, ne_seq};
  assign in_win = !diff[SEQ_W] && (diff[SEQ_W-1:0] < SEQ_W'(WINDOW));

  assign slot_sum = {1'b0, ne_slot} + {1'b0, diff[SLOT_W-1:0]};
  assign ins_slot = (slot_sum >= (SLOT_W+1)'(WINDOW)) ?
                    SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW)) : slot_sum[SLOT_W-1:0];

  // the expected sequence wrapping to zero also restarts the slot at zero
  assign next_slot = (ne_slot == SLOT_W'(WINDOW - 1) || ne_seq == '1) ?
                     '0 : ne_slot + SLOT_W'(1);

  assign stat.stored = in_win && !held[ins_slot];
  assign mask_new    = held | (stat.stored ? (WINDOW'(1) << ins_slot) : '0);
  assign final_new   = final_seen | (stat.stored & is_final);
  assign stat.drain  = stat.stored && mask_new[ne_slot];

  // nothing stays held after the drain iff every held run starts at the
  // expected slot: the drain then empties the whole window
  assign prev   = {mask_new[WINDOW-2:0], mask_new[WINDOW-1]};
  assign starts = mask_new & ~prev;
  assign ne_one = WINDOW'(1) << ne_slot;
  assign stat.done = final_new && ((starts & ~ne_one) == '0);

  // look past the slot being delivered, which clears this cycle
  assign stat.next_held = held_next[next_slot];

  always_comb begin
    held_next = held;
    if (ctrl.eval) begin
      held_next = mask_new;
    end else if (ctrl.deliver) begin
      held_next[ne_slot] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= '0;
      final_seen <= 1'b0;
      ne_seq     <= '0;
      ne_slot    <= '0;
    end else begin
      held <= held_next;
      if (ctrl.eval) begin
        final_seen <= final_new;
      end
      if (ctrl.deliver) begin
        ne_seq  <= ne_seq + SEQ_W'(1);
        ne_slot <= next_slot;
      end
    end
  end

  a_deliver_held: assert property (@(posedge clk) disable iff (rst)
    ctrl.deliver |-> held[ne_slot])
    else $error("delivery from a slot that is not held");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    ne_slot <= SLOT_W'(WINDOW - 1))
    else $error("expected slot beyond window");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    ctrl.deliver |=> ne_seq == $past(ne_seq) + SEQ_W'(1))
    else $error("expected sequence did not advance on delivery");

  a_no_double: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.eval && ctrl.deliver))
    else $error("evaluate and deliver requested together");

endmodule

`default_nettype wire

[rtl/core/selective_repeat_receive_window.sv]
// Selective-repeat receive window: packet descriptors in, acknowledgements and
// in-order deliveries out. Uses srrw_pkg, srrw_ram and srrw_window.
// A request is registered, then evaluated in ST_EVAL, which loads the
// acknowledgement into the output register once it is free. A drain then reads
// the slot store in ST_READ and in ST_DELIVER, one slot store read per cycle
// while the output is free. New requests are taken only in ST_IDLE.
// Reset: flags, expected sequence and controller clear at once; the slot store
// is not cleared, only held slots are ever read.
`default_nettype none

module selective_repeat_receive_window #(
  parameter int WINDOW = srrw_pkg::WINDOW_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // [31:0] seq_num, [43:32] payload_length, [75:44] payload_handle, rest zero
  input  wire logic [srrw_pkg::TDATA_W-1:0] s_tdata,
  input  wire logic                         s_tlast,   // is_final
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // [31:0] out_seq, [43:32] out_length, [75:44] out_handle, rest zero
  output logic      [srrw_pkg::TDATA_W-1:0] m_tdata,
  // [0] kind, [1] transfer_done
  output logic      [srrw_pkg::TUSER_W-1:0] m_tuser,
  output logic                              m_tlast    // end_of_run
);

  import srrw_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW);

  state_t state;
  state_t state_next;

  // request held while it is evaluated
  logic [SEQ_W-1:0]    in_seq;
  logic                in_final;
  logic [LEN_W-1:0]    in_len;
  logic [HANDLE_W-1:0] in_handle;

  win_ctrl_t          ctrl;
  win_stat_t          stat;
  logic [SEQ_W-1:0]   ne_seq;
  logic [SLOT_W-1:0]  ne_slot;
  logic [SLOT_W-1:0]  next_slot;
  logic [SLOT_W-1:0]  ins_slot;

  logic               ram_we;
  logic               ram_re;
  logic [SLOT_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic                out_free;
  logic                done_q;
  logic                out_kind;
  logic [SEQ_W-1:0]    out_seq;
  logic [LEN_W-1:0]    out_len;
  logic [HANDLE_W-1:0] out_handle;
  logic                out_eor;
  logic                out_done;

  // output register can take a new result when empty or being emptied
  assign out_free = !m_tvalid || m_tready;

  srrw_window #(
    .WINDOW (WINDOW),
    .SLOT_W (SLOT_W)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .seq       (in_seq),
    .is_final  (in_final),
    .stat      (stat),
    .ne_seq    (ne_seq),
    .ne_slot   (ne_slot),
    .next_slot (next_slot),
    .ins_slot  (ins_slot)
  );

  // slot store: {handle, length} per slot
  srrw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WINDOW),
    .AW    (SLOT_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ins_slot),
    .wdata ({in_handle, in_len}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // a fresh write may hit the expected slot: read it in ST_READ
        if (out_free) begin
          state_next = stat.drain ? ST_READ : ST_IDLE;
        end
      end
      ST_READ: begin
        state_next = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (out_free && !stat.next_held) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    s_tready     = 1'b0;
    ctrl.eval    = 1'b0;
    ctrl.deliver = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = ne_slot;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_EVAL: begin
        ctrl.eval = out_free;
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_DELIVER: begin
        // fetch the following slot while this one goes out
        ctrl.deliver = out_free;
        ram_re       = out_free && stat.next_held;
        ram_raddr    = next_slot;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  assign ram_we = ctrl.eval && stat.stored;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.eval || ctrl.deliver) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // capture the request; hold done for every result of this request
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_seq    <= s_tdata[SEQ_W-1:0];
      in_len    <= s_tdata[SEQ_W +: LEN_W];
      in_handle <= s_tdata[SEQ_W+LEN_W +: HANDLE_W];
      in_final  <= s_tlast;
    end
    if (ctrl.eval) begin
      done_q <= stat.done;
    end
  end

  // output register: acknowledgement first, then deliveries
  always_ff @(posedge clk) begin
    if (ctrl.eval) begin
      out_kind   <= KIND_ACK;
      out_seq    <= in_seq;
      out_len    <= '0;
      out_handle <= '0;
      out_eor    <= !stat.drain;
      out_done   <= stat.done;
    end else if (ctrl.deliver) begin
      out_kind   <= KIND_DELIVER;
      out_seq    <= ne_seq;
      out_len    <= ram_rdata[LEN_W-1:0];
      out_handle <= ram_rdata[LEN_W +: HANDLE_W];
      out_eor    <= !stat.next_held;
      out_done   <= done_q;
    end
  end

  assign m_tdata = {(TDATA_W - SEQ_W - LEN_W - HANDLE_W)'(0), out_handle, out_len, out_seq};
  assign m_tuser = {out_done, out_kind};
  assign m_tlast = out_eor;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !(ctrl.eval || ctrl.deliver))
    else $error("result overwritten while waiting");

  a_drain_read: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> state == ST_DELIVER && $past(ram_raddr) == ne_slot)
    else $error("drain read out of step with expected slot");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_EVAL && !s_tready)
    else $error("request not taken to evaluation");

endmodule

`default_nettype wire
